// ===== rtl/ptu_pkg.sv =====
// shared types and constants for the page translation unit
`timescale 1ns / 1ps
package ptu_pkg;
	localparam int OFFSET_BITS_D   = 13;
	localparam int INNER_BITS_D    = 10;
	localparam int OUTER_ENTRIES_D = 16;
	localparam int FRAME_COUNT_D   = 4096;
	localparam int TLB_SIZE_D      = 16;
	localparam int VA_W    = 32;
	localparam int LEN_W   = 32;
	localparam int FRAME_W = 12;
	localparam int PHYS_W  = 25;
	localparam int CNT_W   = 32;

	typedef enum logic [1:0] {
		REQ_TRANSLATE = 2'd0,
		REQ_MAP       = 2'd1,
		REQ_UNMAP     = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAULT = 2'd1,
		ST_OOM   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_PT_RD,
		S_PT_WAIT,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_UN_RD,
		S_UN_WAIT,
		S_UN_DO,
		S_OUT
	} state_t;
endpackage

// ===== rtl/ptu_tlb.sv =====
// fully associative tlb with first-invalid or round-robin fill
`timescale 1ns / 1ps
module ptu_tlb #(
	parameter int TLB_SIZE = ptu_pkg::TLB_SIZE_D,
	parameter int VPN_W    = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [VPN_W-1:0]            look_vpn,
	output logic                        look_hit,
	output logic [ptu_pkg::FRAME_W-1:0] look_frame,
	input  logic                        fill,
	input  logic [VPN_W-1:0]            fill_vpn,
	input  logic [ptu_pkg::FRAME_W-1:0] fill_frame,
	input  logic                        drop,
	input  logic [VPN_W-1:0]            drop_vpn
);
	localparam int IW = $clog2(TLB_SIZE);
	logic [VPN_W-1:0]            page_q  [TLB_SIZE];
	logic [ptu_pkg::FRAME_W-1:0] frame_q [TLB_SIZE];
	logic [TLB_SIZE-1:0]         valid_q;
	logic [IW-1:0]               ptr_q;
	logic [IW-1:0]               free_idx;
	logic                        any_free;

	always_comb begin
		look_hit   = 1'b0;
		look_frame = '0;
		for (int i = TLB_SIZE - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == look_vpn) begin
				look_hit   = 1'b1;
				look_frame = frame_q[i];
			end
		end
	end

	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = TLB_SIZE - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (fill) begin
			if (any_free) begin
				valid_q[free_idx] <= 1'b1;
			end else begin
				ptr_q <= (ptr_q == IW'(TLB_SIZE - 1)) ? '0 : ptr_q + 1'b1;
			end
		end else if (drop) begin
			for (int i = 0; i < TLB_SIZE; i++) begin
				if (page_q[i] == drop_vpn) valid_q[i] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			page_q[any_free ? free_idx : ptr_q]  <= fill_vpn;
			frame_q[any_free ? free_idx : ptr_q] <= fill_frame;
		end
	end
endmodule

// ===== rtl/page_translation_unit_with_tlb.sv =====
// top level: page table and frame bitmap memories with walk and allocation control
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tdata: virt_addr, length_bytes; tuser: req_type
//  m_axis  | out | m_axis_tvalid/tready | tdata: phys_addr, frame_number, counters
//          |     |                      | tuser: status, tlb_hit
// one item at a time: a tlb hit goes from the page read to the result; a walk reads the page
// table, waits and decides; map allocation then checks the bitmap frame by frame; unmap reads,
// waits and clears page by page; after reset a clearing pass zeroes the page table
// and marks bitmap frames 0 to OUTER_ENTRIES used, the rest free
// the result register holds until taken; the next item is taken once it is gone
`timescale 1ns / 1ps
module page_translation_unit_with_tlb #(
	parameter int OFFSET_BITS   = ptu_pkg::OFFSET_BITS_D,
	parameter int INNER_BITS    = ptu_pkg::INNER_BITS_D,
	parameter int OUTER_ENTRIES = ptu_pkg::OUTER_ENTRIES_D,
	parameter int FRAME_COUNT   = ptu_pkg::FRAME_COUNT_D,
	parameter int TLB_SIZE      = ptu_pkg::TLB_SIZE_D
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata, // virt_addr[31:0], length_bytes[63:32]
	input  logic [1:0]   s_axis_tuser, // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata, // phys_addr, frame_number, lookup_total, miss_total, zero
	output logic [2:0]   m_axis_tuser  // status[1:0], tlb_hit[2]
);
	localparam int VPN_COUNT = OUTER_ENTRIES << INNER_BITS;
	localparam int VPN_W     = $clog2(VPN_COUNT) > 0 ? $clog2(VPN_COUNT) : 1;
	localparam int FI_W      = $clog2(FRAME_COUNT);
	localparam int PAGE_W    = ptu_pkg::VA_W - OFFSET_BITS;
	localparam int FW        = ptu_pkg::FRAME_W;
	localparam int NPG_W     = ptu_pkg::LEN_W - OFFSET_BITS + 1;
	localparam int CLR_N     = VPN_COUNT > FRAME_COUNT ? VPN_COUNT : FRAME_COUNT;
	localparam int CLR_W     = $clog2(CLR_N) + 1;

	ptu_pkg::state_t state_q, state_d;

	logic [FW-1:0] pt_mem [VPN_COUNT];
	logic          bm_mem [FRAME_COUNT];
	logic [FW-1:0] pt_rd_q;
	logic          bm_rd_q;

	logic [1:0]                 req_q;
	logic [ptu_pkg::VA_W-1:0]   va_q;
	logic [NPG_W-1:0]           left_q;
	logic [VPN_W:0]             vpn_q;
	logic [FI_W:0]              fidx_q;
	logic [CLR_W-1:0]           clr_q;
	logic [ptu_pkg::CNT_W-1:0]  lookups_q, misses_q;
	logic                       in_range_q;

	logic [1:0]                 o_status_q;
	logic [ptu_pkg::PHYS_W-1:0] o_phys_q;
	logic [FW-1:0]              o_frame_q;
	logic                       o_hit_q;

	logic [PAGE_W-1:0]          in_page;
	logic                       tlb_hit;
	logic [FW-1:0]              tlb_frame;
	logic                       fill, drop;
	logic [NPG_W-1:0]           in_pages;
	logic [ptu_pkg::LEN_W:0]    len_rnd;

	assign in_page  = s_axis_tdata[31:OFFSET_BITS];
	assign len_rnd  = {1'b0, s_axis_tdata[63:32]} + ((ptu_pkg::LEN_W+1)'(1) << OFFSET_BITS) - 1'b1;
	assign in_pages = (len_rnd[ptu_pkg::LEN_W:OFFSET_BITS] == '0) ? NPG_W'(1)
		: NPG_W'(len_rnd[ptu_pkg::LEN_W:OFFSET_BITS]);

	ptu_tlb #(.TLB_SIZE(TLB_SIZE), .VPN_W(VPN_W)) u_tlb (
		.clk(clk), .arst_n(arst_n),
		.look_vpn(vpn_q[VPN_W-1:0]), .look_hit(tlb_hit), .look_frame(tlb_frame),
		.fill(fill), .fill_vpn(vpn_q[VPN_W-1:0]), .fill_frame(pt_rd_q),
		.drop(drop), .drop_vpn(vpn_q[VPN_W-1:0])
	);

	assign fill = state_q == ptu_pkg::S_DECIDE && req_q == ptu_pkg::REQ_TRANSLATE
		&& pt_rd_q != '0;
	assign drop = state_q == ptu_pkg::S_UN_DO && !vpn_q[VPN_W] && pt_rd_q != '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptu_pkg::S_CLEAR:
				if (clr_q == CLR_W'(CLR_N - 1)) state_d = ptu_pkg::S_IDLE;
			ptu_pkg::S_IDLE:
				if (s_axis_tvalid) state_d = ptu_pkg::S_PT_RD;
			ptu_pkg::S_PT_RD: begin
				if (!in_range_q) state_d = ptu_pkg::S_OUT;
				else if (req_q == ptu_pkg::REQ_TRANSLATE && tlb_hit) state_d = ptu_pkg::S_OUT;
				else if (req_q == ptu_pkg::REQ_UNMAP) state_d = ptu_pkg::S_UN_RD;
				else if (req_q == ptu_pkg::REQ_TRANSLATE || req_q == ptu_pkg::REQ_MAP)
					state_d = ptu_pkg::S_PT_WAIT;
				else state_d = ptu_pkg::S_OUT;
			end
			ptu_pkg::S_PT_WAIT: state_d = ptu_pkg::S_DECIDE;
			ptu_pkg::S_DECIDE:
				if (req_q == ptu_pkg::REQ_MAP && pt_rd_q == '0) state_d = ptu_pkg::S_SCAN_RD;
				else state_d = ptu_pkg::S_OUT;
			ptu_pkg::S_SCAN_RD:
				if (fidx_q == (FI_W+1)'(FRAME_COUNT)) state_d = ptu_pkg::S_OUT;
				else state_d = ptu_pkg::S_SCAN_CHK;
			ptu_pkg::S_SCAN_CHK:
				if (!bm_rd_q) state_d = ptu_pkg::S_OUT;
				else state_d = ptu_pkg::S_SCAN_RD;
			ptu_pkg::S_UN_RD:
				if (vpn_q[VPN_W] || vpn_q >= (VPN_W+1)'(VPN_COUNT)) state_d = ptu_pkg::S_OUT;
				else state_d = ptu_pkg::S_UN_WAIT;
			ptu_pkg::S_UN_WAIT: state_d = ptu_pkg::S_UN_DO;
			ptu_pkg::S_UN_DO:
				if (pt_rd_q == '0 || left_q == NPG_W'(1)) state_d = ptu_pkg::S_OUT;
				else state_d = ptu_pkg::S_UN_RD;
			ptu_pkg::S_OUT:
				if (m_axis_tready) state_d = ptu_pkg::S_IDLE;
			default: state_d = ptu_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = state_q == ptu_pkg::S_IDLE;
		m_axis_tvalid = state_q == ptu_pkg::S_OUT;
		m_axis_tdata  = {3'b0, misses_q, lookups_q, o_frame_q, o_phys_q};
		m_axis_tuser  = {o_hit_q, o_status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptu_pkg::S_CLEAR;
			clr_q     <= '0;
			lookups_q <= '0;
			misses_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ptu_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ptu_pkg::S_PT_RD && req_q == ptu_pkg::REQ_TRANSLATE) begin
				lookups_q <= lookups_q + 1'b1;
				if (!(in_range_q && tlb_hit)) misses_q <= misses_q + 1'b1;
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == ptu_pkg::S_CLEAR) begin
			if (clr_q < CLR_W'(VPN_COUNT))
				pt_mem[clr_q[VPN_W-1:0]] <= '0;
		end else if (state_q == ptu_pkg::S_DECIDE && req_q == ptu_pkg::REQ_MAP) begin
		end else if (state_q == ptu_pkg::S_SCAN_CHK && !bm_rd_q) begin
			pt_mem[vpn_q[VPN_W-1:0]] <= FW'(fidx_q);
		end else if (drop) begin
			pt_mem[vpn_q[VPN_W-1:0]] <= '0;
		end else begin
			pt_rd_q <= pt_mem[vpn_q[VPN_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptu_pkg::S_CLEAR) begin
			if (clr_q < CLR_W'(FRAME_COUNT))
				bm_mem[clr_q[FI_W-1:0]] <= (clr_q <= CLR_W'(OUTER_ENTRIES));
		end else if (state_q == ptu_pkg::S_SCAN_CHK && !bm_rd_q) begin
			bm_mem[fidx_q[FI_W-1:0]] <= 1'b1;
		end else if (drop && {{(32-FW){1'b0}}, pt_rd_q} < 32'(FRAME_COUNT)) begin
			bm_mem[pt_rd_q[FI_W-1:0]] <= 1'b0;
		end else begin
			bm_rd_q <= bm_mem[fidx_q[FI_W-1:0]];
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ptu_pkg::S_IDLE: begin
				req_q      <= s_axis_tuser;
				va_q       <= s_axis_tdata[31:0];
				left_q     <= in_pages;
				in_range_q <= (in_page >> INNER_BITS) < PAGE_W'(OUTER_ENTRIES);
				vpn_q      <= (VPN_W+1)'(in_page);
				fidx_q     <= '0;
				o_status_q <= ptu_pkg::ST_FAULT;
				o_phys_q   <= '0;
				o_frame_q  <= '0;
				o_hit_q    <= 1'b0;
			end
			ptu_pkg::S_PT_RD: begin
				if (in_range_q && req_q == ptu_pkg::REQ_TRANSLATE && tlb_hit) begin
					o_status_q <= ptu_pkg::ST_OK;
					o_hit_q    <= 1'b1;
					o_frame_q  <= tlb_frame;
					o_phys_q   <= ptu_pkg::PHYS_W'({tlb_frame, va_q[OFFSET_BITS-1:0]});
				end
				if (in_range_q && req_q == ptu_pkg::REQ_UNMAP) o_status_q <= ptu_pkg::ST_OK;
			end
			ptu_pkg::S_DECIDE: begin
				if (pt_rd_q != '0) begin
					o_status_q <= ptu_pkg::ST_OK;
					o_frame_q  <= pt_rd_q;
					if (req_q == ptu_pkg::REQ_TRANSLATE)
						o_phys_q <= ptu_pkg::PHYS_W'({pt_rd_q, va_q[OFFSET_BITS-1:0]});
				end else if (req_q == ptu_pkg::REQ_MAP) begin
					o_status_q <= ptu_pkg::ST_OOM;
				end
			end
			ptu_pkg::S_SCAN_CHK: begin
				if (!bm_rd_q) begin
					o_status_q <= ptu_pkg::ST_OK;
					o_frame_q  <= FW'(fidx_q);
				end else begin
					fidx_q <= fidx_q + 1'b1;
				end
			end
			ptu_pkg::S_UN_RD:
				if (vpn_q >= (VPN_W+1)'(VPN_COUNT)) o_status_q <= ptu_pkg::ST_FAULT;
			ptu_pkg::S_UN_DO: begin
				if (pt_rd_q == '0) o_status_q <= ptu_pkg::ST_FAULT;
				vpn_q  <= vpn_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			default: ;
		endcase
	end

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o_hit_q |-> o_status_q == ptu_pkg::ST_OK)
		else $error("tlb hit without ok status");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while result pending");
	a_fill_drop: assert property (@(posedge clk) disable iff (!arst_n) !(fill && drop))
		else $error("tlb fill and drop together");
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the page translation unit: stream stimulus, scoreboard and checks
`timescale 1ns / 1ps
module tb_top;
	localparam int VPNS = ptu_pkg::OUTER_ENTRIES_D << ptu_pkg::INNER_BITS_D;
	localparam logic [1:0] REQ_BAD = 2'd3;

	typedef struct packed {
		ptu_pkg::status_t                status;
		logic [ptu_pkg::PHYS_W-1:0]  phys;
		logic [ptu_pkg::FRAME_W-1:0] frame;
		logic                        hit;
		logic [ptu_pkg::CNT_W-1:0]   lookups;
		logic [ptu_pkg::CNT_W-1:0]   misses;
	} xlat_res_t;

	class xlat_scoreboard;
		logic [ptu_pkg::FRAME_W-1:0] pt [VPNS];
		bit                          used [ptu_pkg::FRAME_COUNT_D];
		logic [13:0]                 tpage [ptu_pkg::TLB_SIZE_D];
		logic [ptu_pkg::FRAME_W-1:0] tframe [ptu_pkg::TLB_SIZE_D];
		bit                          tvalid [ptu_pkg::TLB_SIZE_D];
		int                          rptr;
		logic [ptu_pkg::CNT_W-1:0]   lookups, misses;
		xlat_res_t                   pending [$];
		int                          errors;

		function new();
			for (int i = 0; i < VPNS; i++) pt[i] = '0;
			for (int i = 0; i < ptu_pkg::FRAME_COUNT_D; i++)
				used[i] = (i <= ptu_pkg::OUTER_ENTRIES_D);
			for (int i = 0; i < ptu_pkg::TLB_SIZE_D; i++) begin
				tvalid[i] = 0; tpage[i] = '0; tframe[i] = '0;
			end
			rptr = 0; lookups = '0; misses = '0; errors = 0;
		endfunction

		function void note_request(ptu_pkg::req_t req, logic [31:0] va, logic [31:0] len);
			xlat_res_t r;
			logic [31:0] page, outer;
			int vpn;
			bit inr, found;
			longint pages;
			page = va >> ptu_pkg::OFFSET_BITS_D;
			outer = page >> ptu_pkg::INNER_BITS_D;
			inr = outer < ptu_pkg::OUTER_ENTRIES_D;
			vpn = inr ? int'(page[ptu_pkg::INNER_BITS_D+3:0]) : 0;
			r = '0;
			r.status = ptu_pkg::ST_FAULT;
			if (req == ptu_pkg::REQ_TRANSLATE) begin
				lookups++;
				found = 0;
				if (inr)
					for (int i = 0; i < ptu_pkg::TLB_SIZE_D && !found; i++)
						if (tvalid[i] && tpage[i] == vpn) begin
							found = 1; r.frame = tframe[i];
						end
				if (found) begin
					r.hit = 1; r.status = ptu_pkg::ST_OK;
				end else begin
					misses++;
					if (inr && pt[vpn] != 0) begin
						r.frame = pt[vpn];
						r.status = ptu_pkg::ST_OK;
						tlb_fill(vpn, r.frame);
					end
				end
				if (r.status == ptu_pkg::ST_OK)
					r.phys = {r.frame, va[ptu_pkg::OFFSET_BITS_D-1:0]};
				else
					r.frame = '0;
			end else if (req == ptu_pkg::REQ_MAP) begin
				if (inr) begin
					if (pt[vpn] != 0) begin
						r.frame = pt[vpn]; r.status = ptu_pkg::ST_OK;
					end else begin
						r.status = ptu_pkg::ST_OOM;
						for (int i = 0; i < ptu_pkg::FRAME_COUNT_D; i++)
							if (!used[i]) begin
								used[i] = 1;
								pt[vpn] = ptu_pkg::FRAME_W'(i);
								r.frame = ptu_pkg::FRAME_W'(i);
								r.status = ptu_pkg::ST_OK;
								break;
							end
					end
				end
			end else if (req == ptu_pkg::REQ_UNMAP) begin
				if (inr) begin
					pages = (longint'(len) + 8191) >> ptu_pkg::OFFSET_BITS_D;
					if (pages == 0) pages = 1;
					r.status = ptu_pkg::ST_OK;
					for (longint k = 0; k < pages; k++) begin
						int v;
						v = vpn + int'(k);
						if (v >= VPNS || pt[v] == 0) begin
							r.status = ptu_pkg::ST_FAULT;
							break;
						end
						used[pt[v]] = 0;
						pt[v] = '0;
						for (int i = 0; i < ptu_pkg::TLB_SIZE_D; i++)
							if (tvalid[i] && tpage[i] == v) tvalid[i] = 0;
					end
				end
			end
			r.lookups = lookups;
			r.misses = misses;
			pending.push_back(r);
		endfunction

		function void tlb_fill(int vpn, logic [ptu_pkg::FRAME_W-1:0] f);
			for (int i = 0; i < ptu_pkg::TLB_SIZE_D; i++)
				if (!tvalid[i]) begin
					tvalid[i] = 1; tpage[i] = 14'(vpn); tframe[i] = f;
					return;
				end
			tpage[rptr] = 14'(vpn);
			tframe[rptr] = f;
			rptr = (rptr + 1) % ptu_pkg::TLB_SIZE_D;
		endfunction

		function void check_result(xlat_res_t got);
			xlat_res_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp st=%0d pa=%h fr=%h hit=%b lk=%0d ms=%0d",
						" got st=%0d pa=%h fr=%h hit=%b lk=%0d ms=%0d"},
						exp.status, exp.phys, exp.frame, exp.hit, exp.lookups, exp.misses,
						got.status, got.phys, got.frame, got.hit, got.lookups, got.misses);
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [103:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;

	xlat_scoreboard sb = new();
	bit  calm = 0;
	bit  sent_all = 0;
	longint cycles = 0;
	logic [31:0] mapped [$];

	page_translation_unit_with_tlb uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 10000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result({ptu_pkg::status_t'(m_axis_tuser[1:0]), m_axis_tdata[24:0],
				m_axis_tdata[36:25], m_axis_tuser[2], m_axis_tdata[68:37], m_axis_tdata[100:69]});
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
	end

	task automatic send_req(ptu_pkg::req_t req, logic [31:0] va, logic [31:0] len);
		while (!calm && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {len, va};
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(req, va, len);
		if (req == ptu_pkg::REQ_MAP && va[31:23] < ptu_pkg::OUTER_ENTRIES_D) mapped.push_back(va);
	endtask

	task automatic send_raw(logic [1:0] t, logic [31:0] va, logic [31:0] len);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {len, va};
		s_axis_tuser <= t;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(ptu_pkg::req_t'(t), va, len);
	endtask

	function automatic logic [31:0] rand_va();
		logic [31:0] v;
		int k;
		k = $urandom_range(9);
		v = $urandom;
		if (k < 7) v[31:23] = 9'($urandom_range(1));
		if (k < 5) v[22:17] = '0;
		if (k < 5) v[16:13] = 4'($urandom_range(15));
		if (k >= 3 && k < 5 && mapped.size() > 0) begin
			v[31:13] = mapped[$urandom_range(mapped.size() - 1)][31:13];
		end
		return v;
	endfunction

	initial begin
		logic [31:0] va, len;
		int k;
		@(posedge arst_n);
		@(posedge clk);
		// directed
		send_req(ptu_pkg::REQ_TRANSLATE, 32'h0000_0000, 0);
		send_req(ptu_pkg::REQ_MAP, 32'h0000_0000, 0);
		send_req(ptu_pkg::REQ_TRANSLATE, 32'h0000_1FFF, 0);
		send_req(ptu_pkg::REQ_TRANSLATE, 32'h0000_0ABC, 0);
		send_req(ptu_pkg::REQ_MAP, 32'h0000_0000, 0);
		send_req(ptu_pkg::REQ_MAP, 32'h07FF_FFFF, 0);
		send_req(ptu_pkg::REQ_TRANSLATE, 32'h07FF_E001, 0);
		send_req(ptu_pkg::REQ_MAP, 32'h0800_0000, 0);
		send_req(ptu_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, 0);
		send_req(ptu_pkg::REQ_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(ptu_pkg::REQ_UNMAP, 32'h07FF_E000, 32'hFFFF_FFFF);
		send_req(ptu_pkg::REQ_TRANSLATE, 32'h07FF_E000, 0);
		send_raw(REQ_BAD, 32'h0000_0000, 0);
		send_raw(REQ_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++) send_req(ptu_pkg::REQ_MAP, i << 13, 0);
		send_req(ptu_pkg::REQ_UNMAP, 32'h0000_0000, 32'h0000_6000);
		send_req(ptu_pkg::REQ_UNMAP, 32'h0000_2000, 32'h0000_4001);
		send_req(ptu_pkg::REQ_UNMAP, 32'h0000_2000, 0);
		for (int i = 0; i < 18; i++) send_req(ptu_pkg::REQ_MAP, i << 13, 0);
		// tlb fill then replacement
		for (int i = 0; i < 18; i++) send_req(ptu_pkg::REQ_TRANSLATE, (i << 13) | i, 0);
		// pause until drained
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		// random
		for (int n = 0; n < 1700; n++) begin
			calm = (n >= 600 && n < 800);
			k = $urandom_range(99);
			va = rand_va();
			len = $urandom_range(3) == 0 ? $urandom : $urandom_range(40000);
			if (k < 50) send_req(ptu_pkg::REQ_TRANSLATE, va, len);
			else if (k < 78) send_req(ptu_pkg::REQ_MAP, va, len);
			else if (k < 97) send_req(ptu_pkg::REQ_UNMAP, va, len);
			else send_raw(REQ_BAD, va, len);
		end
		calm = 0;
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== page_translation_unit_with_tlb.f =====
rtl/ptu_pkg.sv
rtl/ptu_tlb.sv
rtl/page_translation_unit_with_tlb.sv
tb/tb_top.sv
